// ===== rtl/core/bwo_pkg.sv =====
// ---------------------------------------------------------------------------
// bwo_pkg
// Shared types, constants and sizing helpers of the band-limited wavetable
// oscillator.
// ---------------------------------------------------------------------------
package bwo_pkg;

  // default sizes
  localparam int TABLE_SIZE_DEF      = 2048;
  localparam int TABLE_COUNT_DEF     = 10;
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int OPCODE_W      = 1;
  localparam int TABLE_SEL_W   = 4;
  localparam int SAMPLE_IDX_W  = 11;
  localparam int SAMPLE_W      = 16;
  localparam int PHASE_INC_W   = 27;
  localparam int START_PHASE_W = 27;
  localparam int TABLE_POS_W   = 16;
  localparam int AMPLITUDE_W   = 16;
  localparam int POS_FRAC_BITS = 12;
  localparam int CFG_DATA_W    = 27;
  localparam int CFG_INDEX_W   = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [AMPLITUDE_W-1:0] AMPLITUDE_RESET = 16'h8000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_INC   = 2'd0,
    REG_TABLE_POS   = 2'd1,
    REG_AMPLITUDE   = 2'd2,
    REG_START_PHASE = 2'd3
  } reg_index_t;

  // back end settings; user keeps stable while items in flight; unchecked
  typedef struct packed {
    logic [TABLE_POS_W-1:0] table_position;
    logic [AMPLITUDE_W-1:0] amplitude;
  } bwo_cfg_t;

  // phase accumulator width: holds values below (size-2) << frac
  function automatic int ph_width(int table_size, int frac_bits);
    return $clog2(table_size - 2) + frac_bits;
  endfunction

  // width of phase plus increment before reduction
  function automatic int sum_width(int table_size, int frac_bits);
    int pw;
    pw = ph_width(table_size, frac_bits);
    return ((pw > PHASE_INC_W) ? pw : PHASE_INC_W) + 1;
  endfunction

  function automatic int mem_aw(int table_size, int table_count);
    return $clog2(table_size * table_count);
  endfunction

  // queue entry: kind, table address, load data, phase
  function automatic int entry_width(int table_size, int table_count, int frac_bits);
    return 1 + mem_aw(table_size, table_count) + SAMPLE_W + ph_width(table_size, frac_bits);
  endfunction

endpackage

// ===== rtl/core/bwo_queue.sv =====
// ---------------------------------------------------------------------------
// bwo_queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
module bwo_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/bwo_front.sv =====
// ---------------------------------------------------------------------------
// bwo_front
// Accepts items and register writes, drops out-of-range loads, stamps each
// tick with the current phase and advances the phase modulo the wrap length.
// ---------------------------------------------------------------------------
module bwo_front #(
  parameter int TABLE_SIZE      = bwo_pkg::TABLE_SIZE_DEF,
  parameter int TABLE_COUNT     = bwo_pkg::TABLE_COUNT_DEF,
  parameter int PHASE_FRAC_BITS = bwo_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [bwo_pkg::OPCODE_W-1:0]          opcode,
  input  logic [bwo_pkg::TABLE_SEL_W-1:0]       table_select,
  input  logic [bwo_pkg::SAMPLE_IDX_W-1:0]      sample_index,
  input  logic signed [bwo_pkg::SAMPLE_W-1:0]   sample_value,
  input  logic                                  cfg_we,
  input  logic [bwo_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [bwo_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  q_push,
  output logic [bwo_pkg::entry_width(TABLE_SIZE, TABLE_COUNT, PHASE_FRAC_BITS)-1:0] q_wdata,
  input  logic                                  q_full,
  output bwo_pkg::bwo_cfg_t                     cfg
);
  import bwo_pkg::*;

  localparam int PH_W   = ph_width(TABLE_SIZE, PHASE_FRAC_BITS);
  localparam int SUM_W  = sum_width(TABLE_SIZE, PHASE_FRAC_BITS);
  localparam int MEM_AW = mem_aw(TABLE_SIZE, TABLE_COUNT);
  // restoring reduction steps: remainder of a SUM_W-bit value by the wrap length
  localparam int KSTEPS = SUM_W - PH_W + 1;
  localparam int STEP_W = (KSTEPS > 1) ? $clog2(KSTEPS) : 1;
  localparam logic [SUM_W-1:0] WRAP_LEN = SUM_W'(TABLE_SIZE - 2) << PHASE_FRAC_BITS;

  logic [PHASE_INC_W-1:0] phase_inc;
  logic [PH_W-1:0]        phase;
  logic                   red_busy;
  logic [STEP_W-1:0]      red_step;
  logic [SUM_W-1:0]       red_val;
  logic [SUM_W-1:0]       red_next;
  logic [SUM_W-1:0]       red_cand;
  logic                   red_last;
  logic                   accept;
  logic                   is_tick;
  logic                   load_ok;
  logic [MEM_AW-1:0]      load_addr;

  assign full    = q_full || red_busy;
  assign accept  = push && !full;
  assign is_tick = (opcode == OP_TICK);
  assign load_ok = (32'(table_select) < TABLE_COUNT) && (32'(sample_index) < TABLE_SIZE);
  assign q_push  = accept && (is_tick || load_ok);

  assign load_addr = MEM_AW'(table_select) * MEM_AW'(TABLE_SIZE) + MEM_AW'(sample_index);
  assign q_wdata   = {is_tick, load_addr, sample_value, phase};

  // one shifted wrap-length compare and subtract per cycle, held by register writes
  assign red_cand = WRAP_LEN << (STEP_W'(KSTEPS - 1) - red_step);
  assign red_next = (red_val >= red_cand) ? red_val - red_cand : red_val;
  assign red_last = (red_step == STEP_W'(KSTEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc          <= '0;
      cfg.table_position <= '0;
      cfg.amplitude      <= AMPLITUDE_RESET;
      phase              <= '0;
      red_busy           <= 1'b0;
      red_step           <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PHASE_INC: begin
          phase_inc <= cfg_data[PHASE_INC_W-1:0];
        end
        REG_TABLE_POS: begin
          cfg.table_position <= cfg_data[TABLE_POS_W-1:0];
        end
        REG_AMPLITUDE: begin
          cfg.amplitude <= cfg_data[AMPLITUDE_W-1:0];
        end
        REG_START_PHASE: begin
          red_val  <= SUM_W'(cfg_data[START_PHASE_W-1:0]);
          red_busy <= 1'b1;
          red_step <= '0;
        end
        default: begin
        end
      endcase
    end else if (red_busy) begin
      red_val  <= red_next;
      red_step <= red_step + 1'b1;
      if (red_last) begin
        red_busy <= 1'b0;
        phase    <= PH_W'(red_next);
      end
    end else if (accept && is_tick) begin
      red_val  <= SUM_W'(phase) + SUM_W'(phase_inc);
      red_busy <= 1'b1;
      red_step <= '0;
    end
  end

endmodule

// ===== rtl/core/bwo_back.sv =====
// ---------------------------------------------------------------------------
// bwo_back
// Holds the table memory, carries out loads and ticks: paired reads in the
// low and high tables, phase blend, crossfade, gain and saturation.
// ---------------------------------------------------------------------------
module bwo_back #(
  parameter int TABLE_SIZE      = bwo_pkg::TABLE_SIZE_DEF,
  parameter int TABLE_COUNT     = bwo_pkg::TABLE_COUNT_DEF,
  parameter int PHASE_FRAC_BITS = bwo_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [bwo_pkg::entry_width(TABLE_SIZE, TABLE_COUNT, PHASE_FRAC_BITS)-1:0] q_rdata,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  bwo_pkg::bwo_cfg_t                    cfg,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [bwo_pkg::SAMPLE_W-1:0]  sample
);
  import bwo_pkg::*;

  localparam int PH_W      = ph_width(TABLE_SIZE, PHASE_FRAC_BITS);
  localparam int MEM_AW    = mem_aw(TABLE_SIZE, TABLE_COUNT);
  localparam int MEM_DEPTH = TABLE_SIZE * TABLE_COUNT;
  localparam int IDX_W     = PH_W - PHASE_FRAC_BITS;
  localparam int TAB_W     = TABLE_POS_W - POS_FRAC_BITS;
  localparam int BP_W      = SAMPLE_W + PHASE_FRAC_BITS + 3;
  localparam int MP_W      = SAMPLE_W + POS_FRAC_BITS + 3;
  localparam int SP_W      = 2 * SAMPLE_W + 3;

  localparam logic [SAMPLE_W-1:0]        SIGN_FLIP = 16'h8000;
  localparam logic signed [BP_W-1:0]     BL_HALF   = BP_W'(1) << (PHASE_FRAC_BITS - 1);
  localparam logic signed [MP_W-1:0]     MX_HALF   = MP_W'(1) << (POS_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_W:0]   MID       = 17'sd32768;
  localparam logic signed [SP_W-1:0]     SC_HALF   = SP_W'(16384);
  localparam logic signed [SP_W-1:0]     SAT_MAX   = SP_W'(32767);
  localparam logic signed [SP_W-1:0]     SAT_MIN   = -SP_W'(32768);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LO    = 5'b00010,
    ST_HI    = 5'b00100,
    ST_MIX   = 5'b01000,
    ST_SCALE = 5'b10000
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rd_a;
  logic [SAMPLE_W-1:0] rd_b;

  // queue head fields
  logic                  h_tick;
  logic [MEM_AW-1:0]     h_addr;
  logic [SAMPLE_W-1:0]   h_data;
  logic [PH_W-1:0]       h_phase;

  logic [IDX_W-1:0]           prev;
  logic [PHASE_FRAC_BITS-1:0] pfrac;
  logic [TAB_W-1:0]           lo_tab;
  logic [TAB_W-1:0]           hi_tab;
  logic [MEM_AW-1:0]          lo_base;
  logic [MEM_AW-1:0]          hi_base;
  logic [MEM_AW-1:0]          ra;
  logic [MEM_AW-1:0]          rb;
  logic                       take;
  logic                       mem_we;
  logic                       mem_re;

  logic [SAMPLE_W-1:0]        s0;
  logic [SAMPLE_W-1:0]        s1;
  logic [SAMPLE_W-1:0]        mix;
  logic [SAMPLE_W-1:0]        bl_a;
  logic [SAMPLE_W-1:0]        bl_b;
  logic signed [SAMPLE_W:0]   bl_d;
  logic signed [BP_W-1:0]     bl_prod;
  logic signed [BP_W-1:0]     bl_sum;
  logic [SAMPLE_W-1:0]        bl_res;
  logic signed [SAMPLE_W:0]   mx_d;
  logic signed [MP_W-1:0]     mx_prod;
  logic signed [MP_W-1:0]     mx_sum;
  logic signed [SAMPLE_W:0]   sc_s;
  logic signed [SP_W-1:0]     sc_prod;
  logic signed [SP_W-1:0]     sc_q;
  logic signed [SAMPLE_W-1:0] sc_sat;
  logic                       out_valid;
  logic                       out_free;

  assign {h_tick, h_addr, h_data, h_phase} = q_rdata;

  assign take   = (state == ST_IDLE) && !q_empty;
  assign q_pop  = take;
  assign mem_we = take && !h_tick;
  assign mem_re = (take && h_tick) || (state == ST_LO);

  // table pair from the position register, both tables clamped at the last
  always_comb begin
    if (32'(cfg.table_position[TABLE_POS_W-1:POS_FRAC_BITS]) > TABLE_COUNT - 1) begin
      lo_tab = TAB_W'(TABLE_COUNT - 1);
    end else begin
      lo_tab = cfg.table_position[TABLE_POS_W-1:POS_FRAC_BITS];
    end
    hi_tab = (32'(lo_tab) < TABLE_COUNT - 1) ? lo_tab + 1'b1 : lo_tab;
  end

  assign lo_base = MEM_AW'(lo_tab) * MEM_AW'(TABLE_SIZE);
  assign hi_base = MEM_AW'(hi_tab) * MEM_AW'(TABLE_SIZE);

  // the phase stays below the wrap length, so the next entry never wraps
  assign ra = (state == ST_LO) ? hi_base + MEM_AW'(prev)
                               : lo_base + MEM_AW'(h_phase[PH_W-1:PHASE_FRAC_BITS]);
  assign rb = ra + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[h_addr] <= h_data;
    end
    if (mem_re) begin
      rd_a <= mem[ra];
      rd_b <= mem[rb];
    end
  end

  // phase blend on offset-binary samples, shared by both tables
  always_comb begin
    bl_a    = rd_a ^ SIGN_FLIP;
    bl_b    = rd_b ^ SIGN_FLIP;
    bl_d    = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
    bl_prod = BP_W'(bl_d) * $signed(BP_W'(pfrac));
    bl_sum  = BP_W'($signed({1'b0, bl_a})) + ((bl_prod + BL_HALF) >>> PHASE_FRAC_BITS);
    bl_res  = bl_sum[SAMPLE_W-1:0];
  end

  // crossfade between the two tables
  always_comb begin
    mx_d    = $signed({1'b0, s1}) - $signed({1'b0, s0});
    mx_prod = MP_W'(mx_d) * $signed(MP_W'(cfg.table_position[POS_FRAC_BITS-1:0]));
    mx_sum  = MP_W'($signed({1'b0, s0})) + ((mx_prod + MX_HALF) >>> POS_FRAC_BITS);
  end

  // gain with round to nearest and saturation
  always_comb begin
    sc_s    = $signed({1'b0, mix}) - MID;
    sc_prod = SP_W'(sc_s) * $signed(SP_W'(cfg.amplitude)) + SC_HALF;
    sc_q    = sc_prod >>> 15;
    if (sc_q > SAT_MAX) begin
      sc_sat = SAMPLE_W'(SAT_MAX);
    end else if (sc_q < SAT_MIN) begin
      sc_sat = SAMPLE_W'(SAT_MIN);
    end else begin
      sc_sat = sc_q[SAMPLE_W-1:0];
    end
  end

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        prev  <= h_phase[PH_W-1:PHASE_FRAC_BITS];
        pfrac <= h_phase[PHASE_FRAC_BITS-1:0];
      end
      ST_LO:   s0  <= bl_res;
      ST_HI:   s1  <= bl_res;
      ST_MIX:  mix <= mx_sum[SAMPLE_W-1:0];
      ST_SCALE: begin
        if (out_free) begin
          sample <= sc_sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take && h_tick) begin
            state <= ST_LO;
          end
        end
        ST_LO:  state <= ST_HI;
        ST_HI:  state <= ST_MIX;
        ST_MIX: state <= ST_SCALE;
        ST_SCALE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_SCALE && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/bandlimited_wavetable_oscillator_top.sv =====
// ---------------------------------------------------------------------------
// bandlimited_wavetable_oscillator_top
// Wavetable oscillator over octave-band tables with phase interpolation,
// table crossfade, gain and saturation; loads fill the tables word by word.
// ---------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  items     in         push / full      opcode, table_select, sample_index,
//                                        sample_value
//  results   out        pop / empty      sample (one per tick, none per load)
//  config    in         cfg_we           cfg_index, cfg_data
//
//  a load is written while the back end is idle; a tick steps through two paired
//  reads of the table memory, low and high phase blends, crossfade, gain.
//  after each tick and each start_phase write, full stays high while the
//  phase is reduced.
//  rst is synchronous; the table memory is not cleared and holds garbage
//  until loaded. a two-entry queue parts front and back; the result waits in
//  an output register; an unread result stalls the back end at the gain stage.
// ---------------------------------------------------------------------------
module bandlimited_wavetable_oscillator_top #(
  parameter int TABLE_SIZE      = bwo_pkg::TABLE_SIZE_DEF,
  parameter int TABLE_COUNT     = bwo_pkg::TABLE_COUNT_DEF,
  parameter int PHASE_FRAC_BITS = bwo_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [bwo_pkg::OPCODE_W-1:0]        opcode,
  input  logic [bwo_pkg::TABLE_SEL_W-1:0]     table_select,
  input  logic [bwo_pkg::SAMPLE_IDX_W-1:0]    sample_index,
  input  logic signed [bwo_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [bwo_pkg::SAMPLE_W-1:0] sample,
  input  logic                                cfg_we,
  input  logic [bwo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bwo_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bwo_pkg::*;

  localparam int ENTRY_W = entry_width(TABLE_SIZE, TABLE_COUNT, PHASE_FRAC_BITS);
  localparam int PH_W    = ph_width(TABLE_SIZE, PHASE_FRAC_BITS);
  localparam int SUM_W   = sum_width(TABLE_SIZE, PHASE_FRAC_BITS);
  localparam logic [SUM_W-1:0] WRAP_LEN = SUM_W'(TABLE_SIZE - 2) << PHASE_FRAC_BITS;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  bwo_cfg_t           cfg;

  bwo_front #(
    .TABLE_SIZE      (TABLE_SIZE),
    .TABLE_COUNT     (TABLE_COUNT),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .table_select (table_select),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .q_full       (q_full),
    .cfg          (cfg)
  );

  bwo_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bwo_back #(
    .TABLE_SIZE      (TABLE_SIZE),
    .TABLE_COUNT     (TABLE_COUNT),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .empty   (empty),
    .pop     (pop),
    .sample  (sample)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("queue popped while empty");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_wdata[ENTRY_W-1]) |-> (SUM_W'(q_wdata[PH_W-1:0]) < WRAP_LEN))
    else $error("tick phase not below wrap length");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the band-limited wavetable oscillator. The table
// windows that ticks read are loaded first, then a directed part and
// randomized segments of ticks and loads run under varied register settings,
// with random push and pop gaps. An in-bench model predicts each sample; the
// monitor compares in order.
// ---------------------------------------------------------------------------
module tb_top;
  import bwo_pkg::*;

  localparam int TAB_LEN     = TABLE_SIZE_DEF;
  localparam int TAB_COUNT   = TABLE_COUNT_DEF;
  localparam int FRAC_W      = PHASE_FRAC_BITS_DEF;
  localparam bit [27:0] PHASE_WRAP = 28'(TAB_LEN - 2) << FRAC_W;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 97;
  // loaded entries at the head and just below the wrap point of every table
  localparam int WIN_HEAD    = 41;
  localparam int WIN_TAIL    = 25;
  // per-tick step bound so a whole segment stays inside the loaded windows
  localparam int MAX_STEP    = 21000;
  localparam int START_BACK  = 20;

  typedef struct {
    op_t                        op;
    logic [TABLE_SEL_W-1:0]     tsel;
    logic [SAMPLE_IDX_W-1:0]    idx;
    logic signed [SAMPLE_W-1:0] value;
    int                         gap;
  } osc_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [OPCODE_W-1:0]        opcode = '0;
  logic [TABLE_SEL_W-1:0]     table_select = '0;
  logic [SAMPLE_IDX_W-1:0]    sample_index = '0;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // oscillator model state
  bit [SAMPLE_W-1:0]      wave_mem [TAB_COUNT][TAB_LEN];
  bit [PHASE_INC_W-1:0]   phase_acc = '0;
  bit [PHASE_INC_W-1:0]   phase_inc = '0;
  bit [TABLE_POS_W-1:0]   tab_pos = '0;
  bit [AMPLITUDE_W-1:0]   gain = AMPLITUDE_RESET;

  osc_item_t                  pending_items[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];

  osc_item_t                  drv_item;
  int                         gap_left;
  bit                         gap_done;
  int                         rx_wait;
  int                         rx_gap_max = 0;
  int                         hold_left;
  bit                         hold_go = 1'b0;
  logic signed [SAMPLE_W-1:0] exp_s;

  int errors = 0;
  int checked = 0;
  int ticks = 0;
  int loads = 0;
  int dropped_loads = 0;
  int cfg_writes = 0;
  int sat_hits = 0;

  bandlimited_wavetable_oscillator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .table_select (table_select),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .empty        (empty),
    .pop          (pop),
    .sample       (sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table word with the sign bit flipped, i.e. offset by half scale
  function automatic longint unsigned biased_word(int t, int i);
    return {~wave_mem[t][i][SAMPLE_W-1], wave_mem[t][i][SAMPLE_W-2:0]};
  endfunction

  function automatic longint unsigned lerp_round(longint unsigned a, longint unsigned b,
                                                 longint unsigned frac, int fbits);
    longint unsigned one;
    one = 64'd1 << fbits;
    return (a * (one - frac) + b * frac + (one >> 1)) >> fbits;
  endfunction

  // sample for the current phase, then advance the phase
  function automatic logic signed [SAMPLE_W-1:0] next_osc_sample();
    int lo_t, hi_t, prev, nxt;
    longint unsigned pfrac, tfrac, s0, s1, mix;
    longint s, q;
    lo_t = tab_pos >> POS_FRAC_BITS;
    if (lo_t > TAB_COUNT - 1) lo_t = TAB_COUNT - 1;
    hi_t = (lo_t < TAB_COUNT - 1) ? lo_t + 1 : lo_t;
    tfrac = tab_pos & ((1 << POS_FRAC_BITS) - 1);
    prev = phase_acc >> FRAC_W;
    nxt = (prev + 1) % TAB_LEN;
    pfrac = phase_acc & ((1 << FRAC_W) - 1);
    s0 = lerp_round(biased_word(lo_t, prev), biased_word(lo_t, nxt), pfrac, FRAC_W);
    s1 = lerp_round(biased_word(hi_t, prev), biased_word(hi_t, nxt), pfrac, FRAC_W);
    mix = lerp_round(s0, s1, tfrac, POS_FRAC_BITS);
    s = longint'(mix) - 32768;
    q = (s * longint'(gain) + 16384) >>> 15;
    if (q > 32767 || q < -32768) sat_hits++;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    phase_acc = 27'((28'(phase_acc) + 28'(phase_inc)) % PHASE_WRAP);
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic void add_item(op_t op, int tsel, int idx, int value, int gap);
    osc_item_t it;
    it.op = op;
    it.tsel = TABLE_SEL_W'(tsel);
    it.idx = SAMPLE_IDX_W'(idx);
    it.value = SAMPLE_W'(value);
    it.gap = gap;
    pending_items.push_back(it);
  endfunction

  function automatic void add_random_item(int gap_max);
    int r, gap;
    r = $urandom_range(99, 0);
    gap = $urandom_range(gap_max, 0);
    if (r < 65)
      add_item(OP_TICK, $urandom_range(15, 0), $urandom_range(2047, 0), $urandom, gap);
    else if (r < 93)
      add_item(OP_LOAD, $urandom_range(TAB_COUNT - 1, 0), $urandom_range(2047, 0),
               $urandom, gap);
    else
      // table select past the last table, dropped by the block
      add_item(OP_LOAD, $urandom_range(15, TAB_COUNT), $urandom_range(2047, 0),
               $urandom, gap);
  endfunction

  // driver: one transaction per accepted push
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      gap_left = 0;
      gap_done = 1'b0;
    end else begin
      if (push && !full) begin
        if (drv_item.op == OP_TICK) begin
          expected_samples.push_back(next_osc_sample());
          ticks++;
        end else if (drv_item.tsel < TAB_COUNT) begin
          wave_mem[drv_item.tsel][drv_item.idx] = drv_item.value;
          loads++;
        end else begin
          dropped_loads++;
        end
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_items.size() > 0 && !gap_done && pending_items[0].gap > 0) begin
          gap_left = pending_items[0].gap - 1;
          gap_done = 1'b1;
          push <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drv_item = pending_items.pop_front();
          gap_done = 1'b0;
          opcode <= drv_item.op;
          table_select <= drv_item.tsel;
          sample_index <= drv_item.idx;
          sample_value <= drv_item.value;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor: checks each popped sample against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        checked++;
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected sample %0d, nothing predicted", sample);
        end else begin
          exp_s = expected_samples.pop_front();
          if (sample !== exp_s) begin
            errors++;
            if (errors <= 10)
              $display("sample mismatch: expected %0d, got %0d", exp_s, sample);
          end
        end
        rx_wait = $urandom_range(rx_gap_max, 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      pop <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // wait until nothing is queued, in flight or predicted
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || push || expected_samples.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t which, bit [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    case (which)
      REG_PHASE_INC:   phase_inc = value;
      REG_TABLE_POS:   tab_pos = value[TABLE_POS_W-1:0];
      REG_AMPLITUDE:   gain = value[AMPLITUDE_W-1:0];
      REG_START_PHASE: phase_acc = 27'(28'(value) % PHASE_WRAP);
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_regs(bit [CFG_DATA_W-1:0] inc, bit [CFG_DATA_W-1:0] pos,
                          bit [CFG_DATA_W-1:0] amp, bit [CFG_DATA_W-1:0] start);
    write_reg(REG_PHASE_INC, inc);
    write_reg(REG_TABLE_POS, pos);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_START_PHASE, start);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int t, i, v, seg, n, tx_gap_max;
    bit [CFG_DATA_W-1:0] inc_v;
    bit [CFG_DATA_W-1:0] start_v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // load the head and the entries below the wrap point of every table;
    // ticks read inside these windows, but for mid-table entries loaded later
    // table 0 starts with full-scale positive then full-scale negative pairs
    for (t = 0; t < TAB_COUNT; t++)
      for (i = 0; i < TAB_LEN - 1; i++) begin
        if (i < WIN_HEAD || i >= TAB_LEN - 1 - WIN_TAIL) begin
          if (t == 0 && i < 2) v = 32'h7fff;
          else if (t == 0 && i < 4) v = 32'h8000;
          else v = $urandom;
          add_item(OP_LOAD, t, i, v, 0);
        end
      end
    settle();

    // saturation both ways at maximum gain, zero gain, zero phase
    set_regs(0, 0, 16'hffff, 0);
    add_item(OP_TICK, 0, 0, 0, 0);
    settle();
    set_regs(0, 0, 16'hffff, 2 << FRAC_W);
    add_item(OP_TICK, 0, 0, 0, 3);
    settle();
    set_regs(0, 0, 0, 2 << FRAC_W);
    add_item(OP_TICK, 0, 0, 0, 0);
    settle();

    // loads right before a tick that reads them; dropped loads in between
    set_regs(0, 16'h0800, AMPLITUDE_RESET, 0);
    add_item(OP_LOAD, 0, 0, 16'h1234, 0);
    add_item(OP_LOAD, 1, 0, 16'h8000, 0);
    add_item(OP_LOAD, 15, 0, 16'h7fff, 0);
    add_item(OP_LOAD, TAB_COUNT, 2047, 16'h8000, 0);
    add_item(OP_TICK, 0, 0, 0, 0);
    settle();

    // table index past the last table, largest start phase and increment
    set_regs(27'h7ffffff, 16'hffff, AMPLITUDE_RESET, 27'h7ffffff);
    repeat (4) add_item(OP_TICK, 0, 0, 0, 1);
    settle();

    // top of the table range, half-table increment, phase just below the wrap;
    // the half-table step lands mid-table, so those entries are loaded first
    set_regs(67108864, 40959, 32768, PHASE_WRAP - 1);
    add_item(OP_LOAD, TAB_COUNT - 1, 1023, $urandom, 0);
    add_item(OP_LOAD, TAB_COUNT - 1, 1024, $urandom, 0);
    repeat (3) add_item(OP_TICK, 0, 0, 0, 0);
    add_item(OP_LOAD, TAB_COUNT - 1, 2047, 16'h8000, 2);
    add_item(OP_LOAD, 0, 1, 16'h7fff, 0);
    settle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      // small effective steps, some reached through a wrap-length offset
      case ($urandom_range(3, 0))
        0: inc_v = CFG_DATA_W'($urandom_range(MAX_STEP, 0));
        1: inc_v = CFG_DATA_W'(PHASE_WRAP) + CFG_DATA_W'($urandom_range(MAX_STEP, 0));
        2: inc_v = CFG_DATA_W'($urandom_range(255, 0));
        default: inc_v = (seg % 2) ? CFG_DATA_W'(PHASE_WRAP) : '0;
      endcase
      if ($urandom_range(1, 0) == 0)
        // just below the wrap point; larger steps cross it during the segment
        start_v = CFG_DATA_W'(PHASE_WRAP) - CFG_DATA_W'(START_BACK << FRAC_W)
                  + CFG_DATA_W'($urandom_range(2 << FRAC_W, 0));
      else
        // past the wrap length, reduced when loaded
        start_v = CFG_DATA_W'(PHASE_WRAP)
                  + CFG_DATA_W'($urandom_range((2 << FRAC_W) - 1, 0));
      set_regs(inc_v,
               (seg % 2) ? $urandom_range(65535, 0) : $urandom_range(40959, 0),
               ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                           : $urandom_range(32768, 0),
               start_v);
      tx_gap_max = (seg % 3 == 1) ? 0 : 14;
      rx_gap_max = (seg % 4 == 0) ? 0 : 14;
      if (seg == 5) begin
        // stall the receiver while the sender streams back to back
        tx_gap_max = 0;
        for (n = 0; n < SEG_ITEMS; n++) add_random_item(tx_gap_max);
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
      end else if (seg == 8) begin
        // sender pauses mid-segment until every sample has come back
        for (n = 0; n < SEG_ITEMS / 2; n++) add_random_item(tx_gap_max);
        settle();
        for (n = SEG_ITEMS / 2; n < SEG_ITEMS; n++) add_random_item(tx_gap_max);
      end else begin
        for (n = 0; n < SEG_ITEMS; n++) add_random_item(tx_gap_max);
      end
      settle();
    end

    repeat (20) @(negedge clk);
    if (expected_samples.size() != 0) errors++;
    $display("covered %0d ticks, %0d table loads, %0d dropped loads, %0d register writes",
             ticks, loads, dropped_loads, cfg_writes);
    $display("%0d samples checked, %0d saturated, %0d failures", checked, sat_hits, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d samples outstanding", expected_samples.size());
    $display("status: fail");
    $finish;
  end

endmodule
